FILE: rtl/hid_report_to_terminal_bytes_macros.svh
// Assertion macros for the terminal byte encoder
`ifndef HID_REPORT_TO_TERMINAL_BYTES_MACROS_SVH
`define HID_REPORT_TO_TERMINAL_BYTES_MACROS_SVH
`ifndef SYNTHESIS
`define HRTB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("hrtb: implication check failed");
`define HRTB_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("hrtb: forbidden condition seen");
`else
`define HRTB_ASSERT_IMP(lbl, ante, cons)
`define HRTB_ASSERT_NEVER(lbl, expr)
`endif
`endif

FILE: rtl/hrtb_pkg.sv
package hrtb_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int ENC_MAX   = 7;

	localparam logic [1:0] CMD_REPORT = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [2:0] CFG_REP_EN     = 3'd0;
	localparam logic [2:0] CFG_REP_DELAY  = 3'd1;
	localparam logic [2:0] CFG_REP_PERIOD = 3'd2;
	localparam logic [2:0] CFG_CRLF       = 3'd3;
	localparam logic [2:0] CFG_BS_DEL     = 3'd4;
	localparam logic [2:0] CFG_ALT_ESC    = 3'd5;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] modifier_bits;
		logic [7:0] key_slot0;
		logic [7:0] key_slot1;
		logic [7:0] key_slot2;
		logic [7:0] key_slot3;
		logic [7:0] key_slot4;
		logic [7:0] key_slot5;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [ENC_MAX-1:0][7:0] bytes;
		logic [2:0]              n;
		logic                    caps_toggle;
		logic                    rep_ok;
	} enc_t;

	typedef struct packed {
		logic load;
		logic held_chk;
		logic slot_enc;
		logic slot_next;
		logic commit;
		logic tick;
		logic clear;
		logic emit;
		logic flush;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       buf_done;
		logic       out_free;
		logic       pend_v;
		logic       slot_last;
	} dp_stat_t;

endpackage

FILE: rtl/hrtb_encode.sv
module hrtb_encode (
	input  logic [7:0]    key,
	input  logic [7:0]    mods,
	input  logic          caps,
	input  logic          crlf,
	input  logic          bs_del,
	input  logic          alt_esc,
	output hrtb_pkg::enc_t enc
);

	function automatic hrtb_pkg::enc_t push(hrtb_pkg::enc_t e, logic [7:0] b);
		hrtb_pkg::enc_t r;
		r = e;
		r.bytes[r.n] = b;
		r.n = r.n + 3'd1;
		return r;
	endfunction

	function automatic hrtb_pkg::enc_t csi_letter(hrtb_pkg::enc_t e, logic [7:0] fin,
			logic [3:0] p);
		hrtb_pkg::enc_t r;
		r = push(e, 8'h1B);
		r = push(r, 8'h5B);
		if (p != 4'd1) begin
			r = push(r, 8'h31);
			r = push(r, 8'h3B);
			r = push(r, 8'h30 + {4'b0, p});
		end
		r = push(r, fin);
		return r;
	endfunction

	function automatic hrtb_pkg::enc_t csi_tilde(hrtb_pkg::enc_t e, logic two,
			logic [7:0] tens, logic [7:0] ones, logic [3:0] p);
		hrtb_pkg::enc_t r;
		r = push(e, 8'h1B);
		r = push(r, 8'h5B);
		if (two) begin
			r = push(r, tens);
		end
		r = push(r, ones);
		if (p != 4'd1) begin
			r = push(r, 8'h3B);
			r = push(r, 8'h30 + {4'b0, p});
		end
		r = push(r, 8'h7E);
		return r;
	endfunction

	// {valid, char}
	function automatic logic [8:0] ascii(logic [7:0] k, logic sh, logic cp);
		logic [8:0] r;
		r = '0;
		if (k >= 8'h04 && k <= 8'h1D) begin
			r = {1'b1, ((sh ^ cp) ? 8'h41 : 8'h61) + (k - 8'h04)};
		end else if (k >= 8'h1E && k <= 8'h27) begin
			if (!sh) begin
				r = {1'b1, (k == 8'h27) ? 8'h30 : 8'h31 + (k - 8'h1E)};
			end else begin
				case (k)
					8'h1E: r = {1'b1, 8'h21};
					8'h1F: r = {1'b1, 8'h40};
					8'h20: r = {1'b1, 8'h23};
					8'h21: r = {1'b1, 8'h24};
					8'h22: r = {1'b1, 8'h25};
					8'h23: r = {1'b1, 8'h5E};
					8'h24: r = {1'b1, 8'h26};
					8'h25: r = {1'b1, 8'h2A};
					8'h26: r = {1'b1, 8'h28};
					default: r = {1'b1, 8'h29};
				endcase
			end
		end else if (k == 8'h2C) begin
			r = {1'b1, 8'h20};
		end else if (k >= 8'h2D && k <= 8'h38) begin
			case (k)
				8'h2D: r = {1'b1, sh ? 8'h5F : 8'h2D};
				8'h2E: r = {1'b1, sh ? 8'h2B : 8'h3D};
				8'h2F: r = {1'b1, sh ? 8'h7B : 8'h5B};
				8'h30: r = {1'b1, sh ? 8'h7D : 8'h5D};
				8'h31: r = {1'b1, sh ? 8'h7C : 8'h5C};
				8'h33: r = {1'b1, sh ? 8'h3A : 8'h3B};
				8'h34: r = {1'b1, sh ? 8'h22 : 8'h27};
				8'h35: r = {1'b1, sh ? 8'h7E : 8'h60};
				8'h36: r = {1'b1, sh ? 8'h3C : 8'h2C};
				8'h37: r = {1'b1, sh ? 8'h3E : 8'h2E};
				8'h38: r = {1'b1, sh ? 8'h3F : 8'h2F};
				default: r = '0;
			endcase
		end else if (k >= 8'h54 && k <= 8'h63) begin
			case (k)
				8'h54: r = {1'b1, 8'h2F};
				8'h55: r = {1'b1, 8'h2A};
				8'h56: r = {1'b1, 8'h2D};
				8'h57: r = {1'b1, 8'h2B};
				8'h58: r = '0;
				8'h62: r = {1'b1, 8'h30};
				8'h63: r = {1'b1, 8'h2E};
				default: r = {1'b1, 8'h31 + (k - 8'h59)};
			endcase
		end else if (k == 8'h67) begin
			r = {1'b1, 8'h3D};
		end
		return r;
	endfunction

	// F5..F12 tilde codes as two characters
	function automatic logic [15:0] fcode(logic [7:0] k);
		logic [15:0] r;
		case (k)
			8'h3E: r = {8'h31, 8'h35};
			8'h3F: r = {8'h31, 8'h37};
			8'h40: r = {8'h31, 8'h38};
			8'h41: r = {8'h31, 8'h39};
			8'h42: r = {8'h32, 8'h30};
			8'h43: r = {8'h32, 8'h31};
			8'h44: r = {8'h32, 8'h33};
			default: r = {8'h32, 8'h34};
		endcase
		return r;
	endfunction

	logic       m_ctrl, m_shift, m_alt, altp;
	logic [3:0] p;
	logic [8:0] asc;
	logic [8:0] cc;
	logic [15:0] fc;

	assign m_ctrl  = |(mods & 8'h11);
	assign m_shift = |(mods & 8'h22);
	assign m_alt   = |(mods & 8'h44);
	assign altp    = alt_esc & m_alt;
	assign p       = 4'd1 + {3'b0, m_shift} + {2'b0, m_alt, 1'b0} + {1'b0, m_ctrl, 2'b0};
	assign asc     = ascii(key, m_shift, caps);
	assign fc      = fcode(key);

	always_comb begin
		case (key)
			8'h2F: cc = {1'b1, 8'h1B};
			8'h31: cc = {1'b1, 8'h1C};
			8'h30: cc = {1'b1, 8'h1D};
			8'h23: cc = {1'b1, 8'h1E};
			8'h2D: cc = {1'b1, 8'h1F};
			8'h2A: cc = {1'b1, 8'h08};
			8'h28: cc = {1'b1, 8'h0D};
			8'h2B: cc = {1'b1, 8'h09};
			default: cc = (key >= 8'h04 && key <= 8'h1D) ?
				{1'b1, 8'h01 + (key - 8'h04)} : 9'h0;
		endcase
	end

	always_comb begin
		enc = '0;
		if (key < 8'h04) begin
		end else if (key == 8'h39) begin
			enc.caps_toggle = 1'b1;
		end else if (m_ctrl && cc[8]) begin
			if (altp) begin
				enc = push(enc, 8'h1B);
			end
			enc = push(enc, cc[7:0]);
		end else begin
			case (key)
				8'h28: begin
					if (altp) enc = push(enc, 8'h1B);
					enc = push(enc, 8'h0D);
					if (crlf) enc = push(enc, 8'h0A);
				end
				8'h29: enc = push(enc, 8'h1B);
				8'h2A: begin
					if (altp) enc = push(enc, 8'h1B);
					enc = push(enc, bs_del ? 8'h7F : 8'h08);
				end
				8'h2B: begin
					if (altp) enc = push(enc, 8'h1B);
					enc = push(enc, 8'h09);
				end
				8'h52: enc = csi_letter(enc, 8'h41, p);
				8'h51: enc = csi_letter(enc, 8'h42, p);
				8'h4F: enc = csi_letter(enc, 8'h43, p);
				8'h50: enc = csi_letter(enc, 8'h44, p);
				8'h4A: enc = csi_letter(enc, 8'h48, p);
				8'h4D: enc = csi_letter(enc, 8'h46, p);
				8'h49: enc = csi_tilde(enc, 1'b0, 8'h30, 8'h32, p);
				8'h4C: enc = csi_tilde(enc, 1'b0, 8'h30, 8'h33, p);
				8'h4B: enc = csi_tilde(enc, 1'b0, 8'h30, 8'h35, p);
				8'h4E: enc = csi_tilde(enc, 1'b0, 8'h30, 8'h36, p);
				8'h58: begin
					enc = push(enc, 8'h0D);
					if (crlf) enc = push(enc, 8'h0A);
				end
				default: begin
					if (key >= 8'h3A && key <= 8'h3D) begin
						enc = push(enc, 8'h1B);
						enc = push(enc, 8'h4F);
						enc = push(enc, 8'h50 + (key - 8'h3A));
					end else if (key >= 8'h3E && key <= 8'h45) begin
						enc = csi_tilde(enc, 1'b1, fc[15:8], fc[7:0], p);
					end else if (asc[8]) begin
						if (altp) enc = push(enc, 8'h1B);
						enc = push(enc, asc[7:0]);
					end
				end
			endcase
		end
		case (key)
			8'h52, 8'h51, 8'h4F, 8'h50, 8'h2A, 8'h4C, 8'h4A, 8'h4D, 8'h4B, 8'h4E:
				enc.rep_ok = !m_ctrl;
			default: enc.rep_ok = !m_ctrl && asc[8];
		endcase
	end

endmodule

FILE: rtl/hrtb_ctrl.sv
module hrtb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic [1:0]          item_cmd,
	output logic                item_ready,
	input  hrtb_pkg::dp_stat_t  st,
	output hrtb_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HELD  = 3'd1;
	localparam logic [2:0] S_SLOT  = 3'd2;
	localparam logic [2:0] S_TICK  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					unique case (item_cmd)
						hrtb_pkg::CMD_REPORT: state_d = S_HELD;
						hrtb_pkg::CMD_TICK:   state_d = S_TICK;
						hrtb_pkg::CMD_CLEAR:  cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			S_HELD: begin
				cmd.held_chk = 1'b1;
				state_d      = S_SLOT;
			end
			S_SLOT: begin
				cmd.slot_enc = 1'b1;
				state_d      = S_EMIT;
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (!st.buf_done) begin
					cmd.emit = !st.pend_v || st.out_free;
				end else if (st.cmd == hrtb_pkg::CMD_REPORT && !st.slot_last) begin
					cmd.slot_next = 1'b1;
					state_d       = S_SLOT;
				end else begin
					cmd.commit = st.cmd == hrtb_pkg::CMD_REPORT;
					state_d    = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!st.pend_v) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/hrtb_dp.sv
module hrtb_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  hrtb_pkg::item_t     item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  hrtb_pkg::ctrl_cmd_t cmd,
	output hrtb_pkg::dp_stat_t  st,
	input  logic                result_ready,
	output logic                result_valid,
	output hrtb_pkg::result_t   result
);

	localparam int NS = hrtb_pkg::KEY_SLOTS;

	logic        rep_en_q, crlf_q, bs_del_q, alt_esc_q;
	logic [15:0] delay_q, period_q;

	logic [1:0]             cmd_q;
	logic [7:0]             mods_q;
	logic [NS-1:0][7:0]     keys_q;
	logic [NS-1:0][7:0]     prior_q;
	logic [2:0]             slot_q;
	logic                   caps_q;
	logic                   rep_act_q;
	logic [7:0]             rep_key_q, rep_mods_q;
	logic [15:0]            rep_cd_q;

	logic [hrtb_pkg::ENC_MAX-1:0][7:0] buf_q;
	logic [2:0]             blen_q, bidx_q;
	logic [7:0]             pend_q;
	logic                   pend_v_q;
	hrtb_pkg::result_t      out_q;
	logic                   out_v_q;

	logic [7:0]     cur_key, enc_key, enc_mods;
	logic           in_prior, held, is_new, fire;
	hrtb_pkg::enc_t enc;

	assign cur_key = keys_q[slot_q];

	always_comb begin
		in_prior = 1'b0;
		held     = 1'b0;
		for (int i = 0; i < NS; i++) begin
			in_prior = in_prior | (prior_q[i] == cur_key);
			held     = held | (keys_q[i] == rep_key_q);
		end
	end

	assign is_new   = cur_key != 8'h00 && !in_prior;
	assign fire     = rep_en_q && rep_act_q && rep_cd_q <= 16'd1;
	assign enc_key  = cmd.tick ? rep_key_q : cur_key;
	assign enc_mods = cmd.tick ? rep_mods_q : mods_q;

	hrtb_encode u_enc (
		.key     (enc_key),
		.mods    (enc_mods),
		.caps    (caps_q),
		.crlf    (crlf_q),
		.bs_del  (bs_del_q),
		.alt_esc (alt_esc_q),
		.enc     (enc)
	);

	assign st.cmd       = cmd_q;
	assign st.buf_done  = bidx_q == blen_q;
	assign st.out_free  = !out_v_q || result_ready;
	assign st.pend_v    = pend_v_q;
	assign st.slot_last = slot_q == 3'(NS - 1);

	assign result_valid = out_v_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_en_q  <= 1'b1;
			delay_q   <= 16'd480;
			period_q  <= 16'd45;
			crlf_q    <= 1'b0;
			bs_del_q  <= 1'b0;
			alt_esc_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hrtb_pkg::CFG_REP_EN:     rep_en_q  <= cfg_data[0];
				hrtb_pkg::CFG_REP_DELAY:  delay_q   <= cfg_data;
				hrtb_pkg::CFG_REP_PERIOD: period_q  <= cfg_data;
				hrtb_pkg::CFG_CRLF:       crlf_q    <= cfg_data[0];
				hrtb_pkg::CFG_BS_DEL:     bs_del_q  <= cfg_data[0];
				hrtb_pkg::CFG_ALT_ESC:    alt_esc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= hrtb_pkg::CMD_REPORT;
			slot_q     <= '0;
			prior_q    <= '0;
			caps_q     <= 1'b0;
			rep_act_q  <= 1'b0;
			rep_key_q  <= '0;
			rep_mods_q <= '0;
			rep_cd_q   <= '0;
			blen_q     <= '0;
			bidx_q     <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				cmd_q  <= item.command;
				slot_q <= '0;
			end
			if (cmd.clear) begin
				prior_q   <= '0;
				rep_act_q <= 1'b0;
			end
			if (cmd.held_chk && rep_act_q && !held) begin
				rep_act_q <= 1'b0;
			end
			if (cmd.slot_next) begin
				slot_q <= slot_q + 3'd1;
			end
			if (cmd.commit) begin
				prior_q <= keys_q;
			end
			if (cmd.slot_enc) begin
				bidx_q <= '0;
				blen_q <= is_new ? enc.n : 3'd0;
				if (is_new) begin
					caps_q <= caps_q ^ enc.caps_toggle;
					if (enc.n != 3'd0) begin
						if (rep_en_q && enc.rep_ok) begin
							rep_act_q  <= 1'b1;
							rep_key_q  <= cur_key;
							rep_mods_q <= mods_q;
							rep_cd_q   <= delay_q;
						end else begin
							rep_act_q <= 1'b0;
						end
					end
				end
			end
			if (cmd.tick) begin
				bidx_q <= '0;
				blen_q <= fire ? enc.n : 3'd0;
				if (fire) begin
					rep_cd_q <= period_q;
				end else if (rep_en_q && rep_act_q) begin
					rep_cd_q <= rep_cd_q - 16'd1;
				end
			end
			if (cmd.emit) begin
				bidx_q   <= bidx_q + 3'd1;
				pend_v_q <= 1'b1;
			end
			if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if ((cmd.emit && pend_v_q) || cmd.flush) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mods_q <= item.modifier_bits;
			keys_q <= {item.key_slot5, item.key_slot4, item.key_slot3,
				item.key_slot2, item.key_slot1, item.key_slot0};
		end
		if (cmd.slot_enc || cmd.tick) begin
			buf_q <= enc.bytes;
		end
		if (cmd.emit) begin
			pend_q <= buf_q[bidx_q];
		end
		if (cmd.emit && pend_v_q) begin
			out_q <= '{out_byte: pend_q, run_last: 1'b0};
		end else if (cmd.flush) begin
			out_q <= '{out_byte: pend_q, run_last: 1'b1};
		end
	end

endmodule

FILE: rtl/hid_report_to_terminal_bytes.sv
// Turns HID boot keyboard reports, millisecond ticks and attach/detach clears into
// xterm-style terminal bytes, one byte per output transfer, with run_last marking
// the final byte of each input item. For a report, a sequencer visits the six key
// slots one after another, encodes a newly pressed key into a buffer of up to seven
// bytes, then drains that buffer one byte per cycle. The last byte of an item is
// held back one byte so that run_last can be set; output stalls stall the drain.
`include "hid_report_to_terminal_bytes_macros.svh"

module hid_report_to_terminal_bytes (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  hrtb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output hrtb_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	hrtb_pkg::ctrl_cmd_t cmd;
	hrtb_pkg::dp_stat_t  st;

	hrtb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_cmd   (item.command),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	hrtb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.st           (st),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

	`HRTB_ASSERT_IMP(a_idle_no_pending, item_ready, !st.pend_v)
	`HRTB_ASSERT_IMP(a_emit_has_data, cmd.emit, !st.buf_done)
	`HRTB_ASSERT_NEVER(a_emit_flush_clash, cmd.emit && cmd.flush)

endmodule
